// ===== sv/frmp_pkg.sv =====
// Package for the Firmata receive message parser.
// Holds the parse phase type, event kind codes, protocol byte codes and the result struct.
// No dependencies.
package frmp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SHORT = 2'd1,
        PH_SYSEX = 2'd2,
        PH_DROP  = 2'd3
    } t_phase;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_ANALOG   = 3'd0;
    localparam t_kind KIND_DIGITAL  = 3'd1;
    localparam t_kind KIND_PROTOCOL = 3'd2;
    localparam t_kind KIND_FIRMWARE = 3'd3;
    localparam t_kind KIND_I2C_BYTE = 3'd4;
    localparam t_kind KIND_I2C_END  = 3'd5;

    localparam logic [3:0] NIB_DIGITAL = 4'h9;
    localparam logic [3:0] NIB_ANALOG  = 4'hE;
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] CMD_VERSION = 8'hF9;
    localparam logic [7:0] CMD_I2C     = 8'h77;
    localparam logic [7:0] CMD_FIRMWARE = 8'h79;

    localparam logic [8:0] I2C_COUNT_MAX = 9'd256;

    typedef struct packed {
        t_kind       event_kind;
        logic [3:0]  pin_or_port;
        logic [13:0] analog_value;
        logic [12:0] digital_pins;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
        logic [7:0]  i2c_address;
        logic [7:0]  i2c_register;
        logic [7:0]  i2c_byte;
        logic [7:0]  i2c_index;
        logic [8:0]  i2c_count;
    } t_result;

endpackage

// ===== sv/frmp_if.sv =====
// Handshake channels of the Firmata receive message parser: byte input and event output.
// Depends on frmp_pkg for the result struct.
interface frmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frmp_event_if;
    logic             valid;
    logic             ready;
    frmp_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/firmata_receive_message_parser_unit.sv =====
// Firmata receive message parser, top level; uses frmp_pkg and the frmp_if channels.
// An event appears on o_evt in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle; the parse logic sits between the state registers and the
// event register, and i_rx stalls only while a held event is not taken.
// Reset (synchronous, active low): parser idle, pin store cleared, no event pending.
module firmata_receive_message_parser_unit #(
    parameter int DIGITAL_PINS = 13,
    parameter int ANALOG_PINS  = 6,
    parameter int SYSEX_MAX    = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    frmp_byte_if.sink           i_rx,
    frmp_event_if.source        o_evt
);

    localparam int FPW = $clog2(SYSEX_MAX);
    localparam int PW  = (DIGITAL_PINS > 13) ? DIGITAL_PINS : 13;

    frmp_pkg::t_phase      r_phase, n_phase;
    logic [7:0]            r_cmd, n_cmd;
    logic [7:0]            r_held, n_held;
    logic [FPW-1:0]        r_pos, n_pos;
    logic [7:0]            r_sx_cmd, n_sx_cmd;
    logic [7:0]            r_addr, n_addr;
    logic [7:0]            r_reg, n_reg;
    logic [8:0]            r_count, n_count;
    logic [DIGITAL_PINS-1:0] r_pins, n_pins;

    frmp_pkg::t_result     r_out, n_out;
    logic                  r_out_valid;
    logic                  n_emit;

    logic                  accept;
    logic [7:0]            b;
    logic [3:0]            nib;
    logic [7:0]            port_vals;
    logic [PW-1:0]         pins_ext;

    assign i_rx.ready    = !r_out_valid || o_evt.ready;
    assign accept        = i_rx.valid && i_rx.ready;
    assign b             = i_rx.rx_byte;
    assign nib           = r_cmd[3:0];
    assign port_vals     = {b[0], r_held[6:0]};
    assign pins_ext      = PW'(n_pins);
    assign o_evt.valid   = r_out_valid;
    assign o_evt.payload = r_out;

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_held   = r_held;
        n_pos    = r_pos;
        n_sx_cmd = r_sx_cmd;
        n_addr   = r_addr;
        n_reg    = r_reg;
        n_count  = r_count;
        n_pins   = r_pins;
        n_out    = '0;
        n_emit   = 1'b0;

        unique case (r_phase)
            frmp_pkg::PH_SHORT: begin
                if (r_pos == FPW'(1)) begin
                    n_held = b;
                    n_pos  = FPW'(2);
                end else begin
                    n_phase = frmp_pkg::PH_IDLE;
                    if (r_cmd == frmp_pkg::CMD_VERSION) begin
                        n_emit              = 1'b1;
                        n_out.event_kind    = frmp_pkg::KIND_PROTOCOL;
                        n_out.version_major = r_held;
                        n_out.version_minor = b;
                    end else if (r_cmd[7:4] == frmp_pkg::NIB_ANALOG) begin
                        if ({1'b0, nib} < 5'(ANALOG_PINS)) begin
                            n_emit             = 1'b1;
                            n_out.event_kind   = frmp_pkg::KIND_ANALOG;
                            n_out.pin_or_port  = nib;
                            n_out.analog_value = {b[6:0], r_held[6:0]};
                        end
                    end else begin
                        // Port n covers pins 8n..8n+7; pins beyond the store are dropped
                        for (int k = 0; k < DIGITAL_PINS; k++) begin
                            if (4'(k >> 3) == nib && (k >> 3) < 16) begin
                                n_pins[k] = port_vals[3'(k)];
                            end
                        end
                        n_emit             = 1'b1;
                        n_out.event_kind   = frmp_pkg::KIND_DIGITAL;
                        n_out.pin_or_port  = nib;
                        n_out.digital_pins = pins_ext[12:0];
                    end
                end
            end
            frmp_pkg::PH_SYSEX: begin
                if (b == frmp_pkg::SYSEX_END) begin
                    n_phase = frmp_pkg::PH_IDLE;
                    if (r_sx_cmd == frmp_pkg::CMD_I2C) begin
                        n_emit            = 1'b1;
                        n_out.event_kind  = frmp_pkg::KIND_I2C_END;
                        n_out.i2c_address = r_addr;
                        n_out.i2c_register = r_reg;
                        n_out.i2c_count   = r_count;
                    end else if (r_sx_cmd == frmp_pkg::CMD_FIRMWARE) begin
                        n_emit              = 1'b1;
                        n_out.event_kind    = frmp_pkg::KIND_FIRMWARE;
                        n_out.version_major = r_addr;
                        n_out.version_minor = r_reg;
                    end
                end else if (r_pos >= FPW'(SYSEX_MAX - 1)) begin
                    // Frame too long: drop everything up to the end byte
                    n_phase = frmp_pkg::PH_DROP;
                end else begin
                    n_pos = r_pos + FPW'(1);
                    if (r_pos == FPW'(1)) begin
                        n_sx_cmd = b;
                    end else if (r_sx_cmd == frmp_pkg::CMD_FIRMWARE) begin
                        if (r_pos == FPW'(2)) begin
                            n_addr = b;
                        end else if (r_pos == FPW'(3)) begin
                            n_reg = b;
                        end
                    end else if (r_sx_cmd == frmp_pkg::CMD_I2C) begin
                        if (!r_pos[0]) begin
                            n_held = {1'b0, b[6:0]};
                        end else if (r_pos == FPW'(3)) begin
                            n_addr = {b[0], r_held[6:0]};
                        end else if (r_pos == FPW'(5)) begin
                            n_reg = {b[0], r_held[6:0]};
                        end else if (r_count < frmp_pkg::I2C_COUNT_MAX) begin
                            n_emit             = 1'b1;
                            n_out.event_kind   = frmp_pkg::KIND_I2C_BYTE;
                            n_out.i2c_address  = r_addr;
                            n_out.i2c_register = r_reg;
                            n_out.i2c_byte     = {b[0], r_held[6:0]};
                            n_out.i2c_index    = r_count[7:0];
                            n_count            = r_count + 9'd1;
                        end
                    end
                end
            end
            frmp_pkg::PH_DROP: begin
                if (b == frmp_pkg::SYSEX_END) begin
                    n_phase = frmp_pkg::PH_IDLE;
                end
            end
            default: begin
                if (b[7]) begin
                    if (b[7:4] == frmp_pkg::NIB_DIGITAL || b[7:4] == frmp_pkg::NIB_ANALOG ||
                        b == frmp_pkg::CMD_VERSION) begin
                        n_cmd   = b;
                        n_pos   = FPW'(1);
                        n_phase = frmp_pkg::PH_SHORT;
                    end else if (b == frmp_pkg::SYSEX_START) begin
                        n_cmd    = b;
                        n_pos    = FPW'(1);
                        n_sx_cmd = '0;
                        n_addr   = '0;
                        n_reg    = '0;
                        n_count  = '0;
                        n_held   = '0;
                        n_phase  = frmp_pkg::PH_SYSEX;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= frmp_pkg::PH_IDLE;
            r_pins      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_pins  <= n_pins;
            end
            // Load the event register whenever it is free or being emptied
            if (i_rx.ready) begin
                r_out_valid <= accept && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= n_cmd;
            r_held   <= n_held;
            r_pos    <= n_pos;
            r_sx_cmd <= n_sx_cmd;
            r_addr   <= n_addr;
            r_reg    <= n_reg;
            r_count  <= n_count;
        end
        if (accept && n_emit && i_rx.ready) begin
            r_out <= n_out;
        end
    end

    a_short_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == frmp_pkg::PH_SHORT |-> (r_pos == FPW'(1) || r_pos == FPW'(2)))
        else $error("short message position out of range");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == frmp_pkg::PH_SYSEX |-> r_count <= frmp_pkg::I2C_COUNT_MAX)
        else $error("i2c byte count beyond limit");

    a_analog_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_kind == frmp_pkg::KIND_ANALOG)
        |-> {1'b0, r_out.pin_or_port} < 5'(ANALOG_PINS))
        else $error("analog event for a pin out of range");

    a_sysex_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == frmp_pkg::PH_IDLE && b == frmp_pkg::SYSEX_START)
        |=> r_phase == frmp_pkg::PH_SYSEX)
        else $error("sysex start not taken");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> (r_out_valid && !o_evt.ready))
        else $error("input stalled without a pending event");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for firmata_receive_message_parser_unit: byte stream in, events out.
// Depends on frmp_pkg, the frmp_if channels and the top level; predicts every event itself.

module testbench;
    localparam int PIN_COUNT    = 13;
    localparam int ANALOG_COUNT = 6;
    localparam int FRAME_LIMIT  = 256;

    class event_scoreboard;
        frmp_pkg::t_phase  phase;
        logic [7:0]        command;
        logic [7:0]        held;
        int unsigned       frame_pos;
        logic [7:0]        sysex_cmd;
        logic [7:0]        reply_addr;
        logic [7:0]        reply_reg;
        logic [8:0]        reply_count;
        logic [12:0]       pin_levels;

        frmp_pkg::t_result pending_events[$];
        int unsigned       mismatches;
        int unsigned       bytes_taken;
        int unsigned       events_checked;
        int unsigned       count_by_kind[6];

        function new();
            phase       = frmp_pkg::PH_IDLE;
            command     = '0;
            held        = '0;
            frame_pos   = 0;
            sysex_cmd   = '0;
            reply_addr  = '0;
            reply_reg   = '0;
            reply_count = '0;
            pin_levels  = '0;
            mismatches  = 0;
            bytes_taken = 0;
            events_checked = 0;
            foreach (count_by_kind[k]) count_by_kind[k] = 0;
        endfunction

        function int unsigned pending();
            return pending_events.size();
        endfunction

        // Advance the parser model by one accepted beat and queue any event it yields.
        function void take_byte(input logic [7:0] b);
            frmp_pkg::t_result ev;
            logic [7:0]        vals;
            logic [3:0]        nib;
            int                i;
            ev  = '0;
            nib = command[3:0];
            bytes_taken++;
            case (phase)
                frmp_pkg::PH_SHORT: begin
                    if (frame_pos == 1) begin
                        held      = b;
                        frame_pos = 2;
                    end else begin
                        phase = frmp_pkg::PH_IDLE;
                        if (command == frmp_pkg::CMD_VERSION) begin
                            ev.event_kind    = frmp_pkg::KIND_PROTOCOL;
                            ev.version_major = held;
                            ev.version_minor = b;
                            pending_events.push_back(ev);
                        end else if (command[7:4] == frmp_pkg::NIB_ANALOG) begin
                            if (nib < ANALOG_COUNT) begin
                                ev.event_kind   = frmp_pkg::KIND_ANALOG;
                                ev.pin_or_port  = nib;
                                ev.analog_value = {b[6:0], held[6:0]};
                                pending_events.push_back(ev);
                            end
                        end else begin
                            // port n carries pins 8n..8n+7, bit 7 from bit 0 of the high byte
                            vals = {b[0], held[6:0]};
                            for (i = 0; i < 8; i++) begin
                                if (nib * 8 + i < PIN_COUNT) pin_levels[nib * 8 + i] = vals[i];
                            end
                            ev.event_kind   = frmp_pkg::KIND_DIGITAL;
                            ev.pin_or_port  = nib;
                            ev.digital_pins = pin_levels;
                            pending_events.push_back(ev);
                        end
                    end
                end
                frmp_pkg::PH_SYSEX: begin
                    if (b == frmp_pkg::SYSEX_END) begin
                        phase = frmp_pkg::PH_IDLE;
                        if (sysex_cmd == frmp_pkg::CMD_I2C) begin
                            ev.event_kind   = frmp_pkg::KIND_I2C_END;
                            ev.i2c_address  = reply_addr;
                            ev.i2c_register = reply_reg;
                            ev.i2c_count    = reply_count;
                            pending_events.push_back(ev);
                        end else if (sysex_cmd == frmp_pkg::CMD_FIRMWARE) begin
                            ev.event_kind    = frmp_pkg::KIND_FIRMWARE;
                            ev.version_major = reply_addr;
                            ev.version_minor = reply_reg;
                            pending_events.push_back(ev);
                        end
                    end else if (frame_pos >= FRAME_LIMIT - 1) begin
                        phase = frmp_pkg::PH_DROP;
                    end else begin
                        if (frame_pos == 1) begin
                            sysex_cmd = b;
                        end else if (sysex_cmd == frmp_pkg::CMD_FIRMWARE) begin
                            if (frame_pos == 2) reply_addr = b;
                            else if (frame_pos == 3) reply_reg = b;
                        end else if (sysex_cmd == frmp_pkg::CMD_I2C) begin
                            if (frame_pos % 2 == 0) begin
                                held = {1'b0, b[6:0]};
                            end else if (frame_pos == 3) begin
                                reply_addr = {b[0], held[6:0]};
                            end else if (frame_pos == 5) begin
                                reply_reg = {b[0], held[6:0]};
                            end else if (reply_count < frmp_pkg::I2C_COUNT_MAX) begin
                                ev.event_kind   = frmp_pkg::KIND_I2C_BYTE;
                                ev.i2c_address  = reply_addr;
                                ev.i2c_register = reply_reg;
                                ev.i2c_byte     = {b[0], held[6:0]};
                                ev.i2c_index    = reply_count[7:0];
                                reply_count++;
                                pending_events.push_back(ev);
                            end
                        end
                        frame_pos++;
                    end
                end
                frmp_pkg::PH_DROP: begin
                    if (b == frmp_pkg::SYSEX_END) phase = frmp_pkg::PH_IDLE;
                end
                default: begin
                    if (b[7]) begin
                        if (b[7:4] == frmp_pkg::NIB_DIGITAL || b[7:4] == frmp_pkg::NIB_ANALOG
                            || b == frmp_pkg::CMD_VERSION) begin
                            command   = b;
                            frame_pos = 1;
                            phase     = frmp_pkg::PH_SHORT;
                        end else if (b == frmp_pkg::SYSEX_START) begin
                            command     = b;
                            frame_pos   = 1;
                            sysex_cmd   = '0;
                            reply_addr  = '0;
                            reply_reg   = '0;
                            reply_count = '0;
                            held        = '0;
                            phase       = frmp_pkg::PH_SYSEX;
                        end
                    end
                end
            endcase
        endfunction

        function void match_field(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_event(input frmp_pkg::t_result got);
            frmp_pkg::t_result want;
            if (pending_events.size() == 0) begin
                $error("unexpected event of kind %0d", got.event_kind);
                mismatches++;
                return;
            end
            want = pending_events.pop_front();
            events_checked++;
            if (want.event_kind <= frmp_pkg::KIND_I2C_END) count_by_kind[want.event_kind]++;
            match_field("event_kind",    want.event_kind,    got.event_kind);
            match_field("pin_or_port",   want.pin_or_port,   got.pin_or_port);
            match_field("analog_value",  want.analog_value,  got.analog_value);
            match_field("digital_pins",  want.digital_pins,  got.digital_pins);
            match_field("version_major", want.version_major, got.version_major);
            match_field("version_minor", want.version_minor, got.version_minor);
            match_field("i2c_address",   want.i2c_address,   got.i2c_address);
            match_field("i2c_register",  want.i2c_register,  got.i2c_register);
            match_field("i2c_byte",      want.i2c_byte,      got.i2c_byte);
            match_field("i2c_index",     want.i2c_index,     got.i2c_index);
            match_field("i2c_count",     want.i2c_count,     got.i2c_count);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    frmp_byte_if  rx_if ();
    frmp_event_if evt_if ();

    event_scoreboard sb;

    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;

    firmata_receive_message_parser_unit #(
        .DIGITAL_PINS (PIN_COUNT),
        .ANALOG_PINS  (ANALOG_COUNT),
        .SYSEX_MAX    (FRAME_LIMIT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_evt   (evt_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("firmata_receive_message_parser_unit test failed");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        evt_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                evt_if.ready = 1'b0;
                hold_left--;
            end else begin
                evt_if.ready = ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && evt_if.valid && evt_if.ready) sb.check_event(evt_if.payload);
    end

    // Called at a falling edge; leaves valid high so back-to-back beats need no toggle.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            rx_if.valid   = 1'b0;
            rx_if.rx_byte = 8'($urandom);
            @(negedge i_clk);
        end
        rx_if.rx_byte = b;
        rx_if.valid   = 1'b1;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        sb.take_byte(b);
        @(negedge i_clk);
    endtask

    // Mostly 7-bit data; some full bytes, optionally never the end-of-frame code.
    function automatic logic [7:0] data_byte(input int full_pct, input bit allow_end);
        logic [7:0] d;
        if ($urandom_range(99) < full_pct) begin
            do d = 8'($urandom); while (!allow_end && d == frmp_pkg::SYSEX_END);
        end else begin
            d = 8'($urandom_range(127));
        end
        return d;
    endfunction

    task automatic send_short(input logic [7:0] cmd, input int full_pct);
        send_byte(cmd);
        send_byte(data_byte(full_pct, 1'b1));
        send_byte(data_byte(full_pct, 1'b1));
    endtask

    task automatic send_sysex(input logic [7:0] cmd, input int n_data, input int full_pct);
        int i;
        send_byte(frmp_pkg::SYSEX_START);
        send_byte(cmd);
        for (i = 0; i < n_data; i++) send_byte(data_byte(full_pct, 1'b0));
        send_byte(frmp_pkg::SYSEX_END);
    endtask

    task automatic send_random_message();
        logic [3:0] nib;
        logic [7:0] cmd;
        nib = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5));
        case ($urandom_range(9))
            0: send_byte(8'($urandom));
            1, 2: send_short({frmp_pkg::NIB_ANALOG, nib}, 10);
            3, 4: send_short({frmp_pkg::NIB_DIGITAL,
                              (nib > 1) ? 4'($urandom_range(15)) : nib}, 10);
            5: send_short(frmp_pkg::CMD_VERSION, 50);
            6: send_sysex(frmp_pkg::CMD_FIRMWARE, int'($urandom_range(4)), 60);
            7, 8: send_sysex(frmp_pkg::CMD_I2C, int'($urandom_range(20)), 15);
            default: begin
                do cmd = 8'($urandom); while (cmd == frmp_pkg::SYSEX_END
                                              || cmd == frmp_pkg::CMD_I2C
                                              || cmd == frmp_pkg::CMD_FIRMWARE);
                send_sysex(cmd, int'($urandom_range(6)), 30);
            end
        endcase
    endtask

    // Hold the sender until every predicted event has been taken.
    task automatic drain();
        rx_if.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    logic [7:0] directed_bytes[26] = '{
        8'h00, 8'h80,
        8'hE0, 8'h7F, 8'h7F,
        8'hE5, 8'hFF, 8'h80,
        8'hE6, 8'h01, 8'h02,
        8'h90, 8'hFF, 8'h01,
        8'h9F, 8'h00, 8'h00,
        8'hF9, 8'hFF, 8'h00,
        8'hF0, 8'h79, 8'hF7,
        8'hF0, 8'h77, 8'hF7
    };

    int idle_plan[4][2] = '{'{0, 0}, '{66, 0}, '{0, 66}, '{22, 22}};

    initial begin
        sb             = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        i_rst_n        = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_bytes[k]) send_byte(directed_bytes[k]);
        drain();

        foreach (idle_plan[p]) begin
            src_idle_pct   = idle_plan[p][0];
            sink_stall_pct = idle_plan[p][1];
            repeat (10) send_random_message();
            drain();
        end

        // Long hold-off on the event side while a frame one byte over the size limit goes in:
        // its i2c beats back up behind the held event, then the overrun drops the rest.
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 400;
        send_sysex(frmp_pkg::CMD_I2C, FRAME_LIMIT - 2, 15);
        drain();

        repeat (5) @(posedge i_clk);
        $display("Run covered %0d bytes over four idle mixes and a long stall; %0d events:",
                 sb.bytes_taken, sb.events_checked);
        $display("  analog %0d, port %0d, protocol %0d, firmware %0d, i2c byte %0d, i2c end %0d",
                 sb.count_by_kind[0], sb.count_by_kind[1], sb.count_by_kind[2],
                 sb.count_by_kind[3], sb.count_by_kind[4], sb.count_by_kind[5]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("firmata_receive_message_parser_unit test passed");
        end else begin
            $display("firmata_receive_message_parser_unit test failed");
        end
        $finish;
    end
endmodule
